[hdl/assert_macros.svh]
// Assertion macros shared by the line blur filter RTL.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same check, built on the macro above.
`define ASSERT_IMPLY(label, clk, rst_n, pre, post, msg) \
	`ASSERT_CLK(label, clk, rst_n, (pre) |-> (post), msg)

`endif

[hdl/lbf_pkg.sv]
// Package for the line blur filter: sizes, register indexes, modes, opcodes and states.
// Depends on nothing.
`default_nettype none
package lbf_pkg;
	localparam int MAX_RADIUS  = 32;
	localparam int SAMPLE_BITS = 16;
	localparam int WEIGHT_BITS = 16;
	localparam int WIN_DEPTH   = 2 * MAX_RADIUS - 1;
	localparam int PTR_W       = $clog2(WIN_DEPTH);
	localparam int DIST_W      = $clog2(MAX_RADIUS);
	localparam int SEEN_W      = 7;
	localparam int SUM_W       = WEIGHT_BITS + $clog2(WIN_DEPTH);
	localparam int ACC_W       = SAMPLE_BITS + WEIGHT_BITS + $clog2(WIN_DEPTH);
	localparam int BIT_W       = $clog2(SAMPLE_BITS);
	localparam int CFG_W       = 16;

	localparam logic [1:0] REG_MODE   = 2'd0;
	localparam logic [1:0] REG_RADIUS = 2'd1;
	localparam logic [1:0] REG_TOL    = 2'd2;

	localparam logic [1:0] MODE_BOX     = 2'd0;
	localparam logic [1:0] MODE_GAUSS   = 2'd1;
	localparam logic [1:0] MODE_SURFACE = 2'd2;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_WEIGHT = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NEXT,
		S_CRD,
		S_CWT,
		S_TAP,
		S_DRAIN,
		S_DIV,
		S_EMIT
	} state_t;
endpackage
`default_nettype wire

[hdl/line_blur_filter.sv]
// Line blur filter top level: window memory, weight table, shared MAC and divider.
// Depends on lbf_pkg and assert_macros.svh.
// A sample starts one sequence per ready result: job setup, centre read, tap walk (taps at
// most 2*radius-1, one a cycle through the shared MAC), MAC drain, divider (one bit a cycle)
// and emit, which waits while the output stalls; input, weight writes too, waits for idle.
// Reset is asynchronous, active low: control and config reset; memories and datapath do not.
`default_nettype none
`include "assert_macros.svh"
module line_blur_filter import lbf_pkg::*; (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [CFG_W-1:0]       cfg_data,
	input  wire logic                   in_valid,
	output logic                        in_stall,
	input  wire logic                   opcode,
	input  wire logic [SAMPLE_BITS-1:0] sample_value,
	input  wire logic                   end_of_line,
	input  wire logic [4:0]             weight_index,
	input  wire logic [WEIGHT_BITS-1:0] weight_value,
	output logic                        out_valid,
	input  wire logic                   out_stall,
	output logic [SAMPLE_BITS-1:0]      filtered_value,
	output logic                        last_of_line
);
	state_t state_q, state_d;

	logic [1:0]             mode_q;
	logic [5:0]             radius_q;
	logic [15:0]            tol_q;

	logic [SAMPLE_BITS-1:0] win_mem [WIN_DEPTH];
	logic [WEIGHT_BITS-1:0] wt_q [MAX_RADIUS];
	logic [SAMPLE_BITS-1:0] rdata_q;

	logic [PTR_W-1:0]       wp_q;
	logic [SEEN_W-1:0]      seen_q;
	logic [SEEN_W-1:0]      n_q;
	logic [DIST_W-1:0]      r_q;
	logic                   norm_q;
	logic [PTR_W-1:0]       fc_q;
	logic                   eol_q;
	logic [PTR_W-1:0]       c_q, o_q, hi_q;
	logic                   last_q;
	logic [SAMPLE_BITS-1:0] centre_q;

	logic                   tap_vld_s1;
	logic [DIST_W-1:0]      dist_s1;
	logic                   prod_vld_s2;
	logic [ACC_W-1:0]       prod_s2;
	logic [SUM_W-1:0]       wsum_s2;
	logic [ACC_W-1:0]       acc_q;
	logic [SUM_W-1:0]       sum_q;
	logic [ACC_W-1:0]       rem_q;
	logic [SAMPLE_BITS-1:0] quo_q;
	logic [BIT_W-1:0]       bit_q;

	logic                   accept;
	logic                   out_free;
	logic [SEEN_W-1:0]      n_new;
	logic [DIST_W-1:0]      r_eff;
	logic [DIST_W-1:0]      top;
	logic [PTR_W-1:0]       sel;
	logic [PTR_W:0]         adiff;
	logic [PTR_W-1:0]       rd_addr;
	logic [PTR_W-1:0]       wp_next;
	logic [PTR_W-1:0]       job_off;
	logic [SEEN_W-1:0]      lc_raw;
	logic [PTR_W-1:0]       lcnt;
	logic                   job_any;
	logic [SAMPLE_BITS-1:0] tap_diff;
	logic                   weighted;
	logic                   tap_in;
	logic [WEIGHT_BITS-1:0] tap_w;
	logic [SAMPLE_BITS+WEIGHT_BITS-1:0] tap_prod;
	logic [ACC_W-1:0]       div_shift;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;

	// Radius below one acts as one, above the maximum as the maximum.
	always_comb begin
		if (radius_q == 6'd0) begin
			r_eff = '0;
		end else if (radius_q > 6'(MAX_RADIUS)) begin
			r_eff = DIST_W'(MAX_RADIUS - 1);
		end else begin
			r_eff = DIST_W'(radius_q - 6'd1);
		end
	end

	assign n_new   = (seen_q < 7'd127) ? seen_q + 7'd1 : seen_q;
	assign top     = (n_new < SEEN_W'(r_eff)) ? DIST_W'(n_new) : r_eff;
	assign wp_next = (wp_q == PTR_W'(WIN_DEPTH - 1)) ? '0 : wp_q + 1'b1;

	// Window offset zero is the newest sample; offsets count back around the ring.
	assign sel   = (state_q == S_TAP) ? o_q : c_q;
	assign adiff = {1'b0, wp_q} - {1'b0, sel};
	assign rd_addr = adiff[PTR_W] ? PTR_W'(adiff + (PTR_W+1)'(WIN_DEPTH)) : adiff[PTR_W-1:0];

	// Next job: the regular result first, then flush results from the oldest down.
	assign job_any = norm_q || (eol_q && fc_q != '0);
	assign job_off = norm_q ? PTR_W'(r_q) : fc_q - 1'b1;
	assign lc_raw  = n_q - 7'd1 - SEEN_W'(job_off);
	assign lcnt    = (lc_raw > SEEN_W'(r_q)) ? PTR_W'(r_q) : PTR_W'(lc_raw);

	assign weighted = (mode_q == MODE_GAUSS) || (mode_q == MODE_SURFACE);
	assign tap_diff = (rdata_q >= centre_q) ? rdata_q - centre_q : centre_q - rdata_q;
	assign tap_in   = (mode_q != MODE_SURFACE) || (tap_diff <= tol_q);
	assign tap_w    = weighted ? wt_q[dist_s1] : WEIGHT_BITS'(1);
	assign tap_prod = tap_w * rdata_q;
	assign div_shift = ACC_W'(sum_q) << bit_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept && opcode == OP_SAMPLE) begin
					state_d = S_NEXT;
				end
			end
			S_NEXT: begin
				state_d = job_any ? S_CRD : S_IDLE;
			end
			S_CRD: begin
				state_d = S_CWT;
			end
			S_CWT: begin
				state_d = S_TAP;
			end
			S_TAP: begin
				if (o_q == hi_q) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!tap_vld_s1 && !prod_vld_s2) begin
					state_d = S_DIV;
				end
			end
			S_DIV: begin
				if (bit_q == '0) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (out_free) begin
					state_d = S_NEXT;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_BOX;
			radius_q    <= 6'd1;
			tol_q       <= 16'hFFFF;
			wp_q        <= '0;
			seen_q      <= '0;
			norm_q      <= 1'b0;
			fc_q        <= '0;
			eol_q       <= 1'b0;
			tap_vld_s1  <= 1'b0;
			prod_vld_s2 <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			state_q     <= state_d;
			tap_vld_s1  <= (state_q == S_TAP);
			prod_vld_s2 <= tap_vld_s1;
			if (cfg_we) begin
				case (cfg_index)
					REG_MODE:   mode_q   <= cfg_data[1:0];
					REG_RADIUS: radius_q <= cfg_data[5:0];
					REG_TOL:    tol_q    <= cfg_data[15:0];
					default:    ;
				endcase
			end
			if (accept && opcode == OP_SAMPLE) begin
				wp_q   <= wp_next;
				seen_q <= end_of_line ? '0 : n_new;
				norm_q <= (n_new >= SEEN_W'(r_eff) + 7'd1);
				fc_q   <= end_of_line ? PTR_W'(top) : '0;
				eol_q  <= end_of_line;
			end
			if (state_q == S_NEXT && job_any) begin
				if (norm_q) begin
					norm_q <= 1'b0;
				end else begin
					fc_q <= fc_q - 1'b1;
				end
			end
			if (state_q == S_EMIT && out_free) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == OP_SAMPLE) begin
			win_mem[wp_next] <= sample_value;
			n_q <= n_new;
			r_q <= r_eff;
		end
		if (accept && opcode == OP_WEIGHT) begin
			wt_q[weight_index[DIST_W-1:0]] <= weight_value;
		end
		rdata_q <= win_mem[rd_addr];
	end

	// Job setup, tap walk, MAC pipeline, divider and output register.
	always_ff @(posedge clk) begin
		dist_s1 <= (o_q >= c_q) ? DIST_W'(o_q - c_q) : DIST_W'(c_q - o_q);
		prod_s2 <= tap_in ? ACC_W'(tap_prod) : '0;
		wsum_s2 <= tap_in ? SUM_W'(tap_w) : '0;
		case (state_q)
			S_NEXT: begin
				c_q    <= job_off;
				hi_q   <= job_off + lcnt;
				o_q    <= '0;
				last_q <= eol_q && (norm_q ? (fc_q == '0) : (fc_q == PTR_W'(1)));
			end
			S_CRD: begin
				acc_q <= '0;
				sum_q <= '0;
			end
			S_CWT: begin
				centre_q <= rdata_q;
			end
			S_TAP: begin
				o_q <= o_q + 1'b1;
			end
			S_DRAIN: begin
				rem_q <= acc_q + ACC_W'(sum_q >> 1);
				quo_q <= '0;
				bit_q <= BIT_W'(SAMPLE_BITS - 1);
			end
			S_DIV: begin
				if (rem_q >= div_shift) begin
					rem_q        <= rem_q - div_shift;
					quo_q[bit_q] <= 1'b1;
				end
				bit_q <= bit_q - 1'b1;
			end
			S_EMIT: begin
				if (out_free) begin
					filtered_value <= (sum_q == '0) ? '0 : quo_q;
					last_of_line   <= last_q;
				end
			end
			default: ;
		endcase
		if (prod_vld_s2) begin
			acc_q <= acc_q + prod_s2;
			sum_q <= sum_q + wsum_s2;
		end
	end

	`ASSERT_IMPLY(a_tap_from_walk, clk, arst_n, tap_vld_s1, $past(state_q == S_TAP),
		"tap entered the MAC outside the window walk")
	`ASSERT_IMPLY(a_div_remainder, clk, arst_n, state_q == S_EMIT && sum_q != '0,
		rem_q < ACC_W'(sum_q), "divider left a remainder not below the divisor")
	`ASSERT_CLK(a_sample_starts, clk, arst_n,
		accept && opcode == OP_SAMPLE |=> state_q == S_NEXT,
		"accepted sample did not start the result sequence")
endmodule
`default_nettype wire
